/* rtl/ehs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehs_pkg
// Request, entry kind and status codes of the exception handler stack.
// ----------------------------------------------------------------------------
package ehs_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_ANNOT   = 3'd0,
		REQ_PUSH_ALL     = 3'd1,
		REQ_PUSH_CATCH   = 3'd2,
		REQ_PUSH_FINALLY = 3'd3,
		REQ_POP          = 3'd4,
		REQ_ANNOT_POP    = 3'd5,
		REQ_RAISE        = 3'd6,
		REQ_CONTINUE     = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		KIND_ANNOT     = 2'd0,
		KIND_CATCH_ALL = 2'd1,
		KIND_CATCH     = 2'd2,
		KIND_FINALLY   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_CAUGHT    = 3'd1,
		ST_FINALLY   = 3'd2,
		ST_UNCAUGHT  = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_UNDERFLOW = 3'd5
	} status_t;

endpackage
`default_nettype wire

/* rtl/ehs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ehs_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 50,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/exception_handler_stack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exception_handler_stack
// Bounded stack of annotation, catch-all, catch and finally entries with
// raise and unwind handling. Entries live in one RAM.
//
//   channel  handshake            fields
//   in       in_valid / in_stall  req_type, class_id, tag
//   out      out_valid/ out_stall status, handler_tag, new_depth, still_unwinding
//
// Push and pop finish in the execute state. On a non-empty stack, annotation
// pop, raise and continue go on to the scan state, where the walk reads one
// RAM entry per cycle through the single read port.
// Reset clears depth, unwinding state and the output beat; entry contents
// stay undefined until pushed. A stalled output holds the finishing step.
// ----------------------------------------------------------------------------
module exception_handler_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int CLASS_BITS  = 16,
	parameter int TAG_BITS    = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic [2:0]                              req_type,
	input  wire logic [CLASS_BITS-1:0]                   class_id,
	input  wire logic [TAG_BITS-1:0]                     tag,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic [2:0]                                   status,
	output logic [TAG_BITS-1:0]                          handler_tag,
	output logic [$clog2(STACK_DEPTH+1)-1:0]             new_depth,
	output logic                                         still_unwinding
);

	import ehs_pkg::*;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W   = $clog2(STACK_DEPTH);

	typedef struct packed {
		kind_t                 kind;
		logic [CLASS_BITS-1:0] cls;
		logic [TAG_BITS-1:0]   tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t                state_q, state_d;
	logic [DEPTH_W-1:0]    top_q, top_d;
	logic [DEPTH_W-1:0]    saved_q, saved_d;
	logic                  unw_q, unw_d;
	logic [CLASS_BITS-1:0] rcls_q, rcls_d;
	logic [DEPTH_W-1:0]    ptr_q, ptr_d;
	req_t                  req_q;
	logic [CLASS_BITS-1:0] cls_q;
	logic [TAG_BITS-1:0]   tag_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [TAG_BITS-1:0]   htag_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic                  unw_out_q;

	logic                  out_free;
	logic                  load;
	status_t               res_status;
	logic [TAG_BITS-1:0]   res_htag;
	logic [DEPTH_W-1:0]    res_depth;
	logic                  res_unw;

	logic [DEPTH_W-1:0]    top_m1, ptr_m1, ptr_m2, eff_saved;
	logic                  we;
	logic [IDX_W-1:0]      rd_addr;
	entry_t                wr_entry, rd_entry;
	logic [ENTRY_W-1:0]    rd_word;
	logic                  is_raise;
	logic                  hit_catch;

	assign top_m1    = top_q - DEPTH_W'(1);
	assign ptr_m1    = ptr_q - DEPTH_W'(1);
	assign ptr_m2    = ptr_q - DEPTH_W'(2);
	assign is_raise  = (req_q == REQ_RAISE);
	assign eff_saved = is_raise ? top_q : saved_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	assign wr_entry.kind = kind_t'(req_q[1:0]);
	assign wr_entry.cls  = (req_q == REQ_PUSH_CATCH) ? cls_q : '0;
	assign wr_entry.tag  = tag_q;
	assign rd_entry      = entry_t'(rd_word);
	assign hit_catch     = (rd_entry.kind == KIND_CATCH_ALL) ||
	                       ((rd_entry.kind == KIND_CATCH) && (rd_entry.cls == rcls_q));

	ehs_ram #(
		.DEPTH  (STACK_DEPTH),
		.WIDTH  (ENTRY_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (top_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	always_comb begin
		state_d    = state_q;
		top_d      = top_q;
		saved_d    = saved_q;
		unw_d      = unw_q;
		rcls_d     = rcls_q;
		ptr_d      = ptr_q;
		we         = 1'b0;
		rd_addr    = ptr_m1[IDX_W-1:0];
		load       = 1'b0;
		res_status = ST_DONE;
		res_htag   = '0;
		res_depth  = top_q;
		res_unw    = unw_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				rd_addr = top_m1[IDX_W-1:0];
				unique case (req_q) inside
					REQ_PUSH_ANNOT, REQ_PUSH_ALL, REQ_PUSH_CATCH, REQ_PUSH_FINALLY: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
							if (top_q == DEPTH_W'(STACK_DEPTH)) begin
								res_status = ST_OVERFLOW;
							end else begin
								we        = 1'b1;
								top_d     = top_q + DEPTH_W'(1);
								res_depth = top_q + DEPTH_W'(1);
							end
						end
					end
					REQ_POP: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
							if (top_q == '0) begin
								res_status = ST_UNDERFLOW;
							end else begin
								top_d     = top_m1;
								res_depth = top_m1;
							end
						end
					end
					REQ_ANNOT_POP: begin
						if (top_q == '0) begin
							if (out_free) begin
								load       = 1'b1;
								state_d    = S_IDLE;
								res_status = ST_UNDERFLOW;
							end
						end else begin
							ptr_d   = top_q;
							state_d = S_SCAN;
						end
					end
					REQ_RAISE, REQ_CONTINUE: begin
						if (top_q == '0) begin
							if (out_free) begin
								load       = 1'b1;
								state_d    = S_IDLE;
								saved_d    = eff_saved;
								rcls_d     = is_raise ? cls_q : rcls_q;
								unw_d      = 1'b0;
								top_d      = eff_saved;
								res_status = ST_UNCAUGHT;
								res_depth  = eff_saved;
								res_unw    = 1'b0;
							end
						end else begin
							if (is_raise) begin
								saved_d = top_q;
								unw_d   = 1'b1;
								rcls_d  = cls_q;
							end
							ptr_d   = top_q;
							state_d = S_SCAN;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (req_q == REQ_ANNOT_POP) begin
					if (rd_entry.kind == KIND_ANNOT) begin
						if (out_free) begin
							load      = 1'b1;
							state_d   = S_IDLE;
							top_d     = ptr_m1;
							res_depth = ptr_m1;
						end
					end else if (ptr_m1 == '0) begin
						if (out_free) begin
							load       = 1'b1;
							state_d    = S_IDLE;
							res_status = ST_UNDERFLOW;
						end
					end else begin
						ptr_d   = ptr_m1;
						rd_addr = ptr_m2[IDX_W-1:0];
					end
				end else begin
					if (hit_catch) begin
						if (out_free) begin
							load       = 1'b1;
							state_d    = S_IDLE;
							top_d      = ptr_m1;
							unw_d      = 1'b0;
							res_status = ST_CAUGHT;
							res_htag   = rd_entry.tag;
							res_depth  = ptr_m1;
							res_unw    = 1'b0;
						end
					end else if (rd_entry.kind == KIND_FINALLY) begin
						if (out_free) begin
							load       = 1'b1;
							state_d    = S_IDLE;
							top_d      = ptr_m1;
							res_status = ST_FINALLY;
							res_htag   = rd_entry.tag;
							res_depth  = ptr_m1;
						end
					end else if (ptr_m1 == '0) begin
						if (out_free) begin
							load       = 1'b1;
							state_d    = S_IDLE;
							top_d      = saved_q;
							unw_d      = 1'b0;
							res_status = ST_UNCAUGHT;
							res_depth  = saved_q;
							res_unw    = 1'b0;
						end
					end else begin
						ptr_d   = ptr_m1;
						rd_addr = ptr_m2[IDX_W-1:0];
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			saved_q     <= '0;
			unw_q       <= 1'b0;
			rcls_q      <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			saved_q <= saved_d;
			unw_q   <= unw_d;
			rcls_q  <= rcls_d;
			ptr_q   <= ptr_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= req_t'(req_type);
			cls_q <= class_id;
			tag_q <= tag;
		end
		if (load) begin
			status_q  <= res_status;
			htag_q    <= res_htag;
			depth_q   <= res_depth;
			unw_out_q <= res_unw;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign handler_tag     = htag_q;
	assign new_depth       = depth_q;
	assign still_unwinding = unw_out_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exception handler stack. A short table of
// requests covers the empty-stack errors, every request kind and a full
// unwind down to the saved depth; random request streams follow, with stack
// fills to overflow, deep walks, random idle on both channels. Each beat is
// checked against a table row's outcome if given, else an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
	import ehs_pkg::*;

	localparam int DEPTH      = 64;
	localparam int RAND_ITEMS = 900;
	localparam int LIMIT      = 600000;
	localparam int TAIL       = 100;

	typedef struct packed {
		status_t     status;
		logic [31:0] handler_tag;
		logic [6:0]  new_depth;
		logic        still_unwinding;
	} outcome_t;

	typedef struct {
		req_t        req;
		logic [15:0] cls;
		logic [31:0] tg;
		bit          typed;
		outcome_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [15:0] class_id;
	logic [31:0] tag;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] handler_tag;
	logic [6:0]  new_depth;
	logic        still_unwinding;

	kind_t       frame_kind  [DEPTH];
	logic [15:0] frame_class [DEPTH];
	logic [31:0] frame_tag   [DEPTH];
	int          sp;
	int          saved_sp;
	logic        unwinding;
	logic [15:0] cur_class;

	outcome_t    expected_q [$];
	row_t        rows [$];
	bit          no_idle = 1'b0;
	int          errors = 0;
	int          sent = 0;
	int          beats = 0;
	int          cycles = 0;
	int          stall_left = 0;
	int          st_seen [8];

	exception_handler_stack u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.class_id        (class_id),
		.tag             (tag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.handler_tag     (handler_tag),
		.new_depth       (new_depth),
		.still_unwinding (still_unwinding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic outcome_t predict_request(req_t req, logic [15:0] cls, logic [31:0] tg);
		outcome_t res;
		int       i;
		bit       found;
		res.status = ST_DONE;
		res.handler_tag = '0;
		found = 1'b0;
		case (req)
			REQ_PUSH_ANNOT, REQ_PUSH_ALL, REQ_PUSH_CATCH, REQ_PUSH_FINALLY: begin
				if (sp >= DEPTH) begin
					res.status = ST_OVERFLOW;
				end else begin
					frame_kind[sp]  = kind_t'(req[1:0]);
					frame_class[sp] = (req == REQ_PUSH_CATCH) ? cls : 16'h0000;
					frame_tag[sp]   = tg;
					sp++;
				end
			end
			REQ_POP: begin
				if (sp == 0)
					res.status = ST_UNDERFLOW;
				else
					sp--;
			end
			REQ_ANNOT_POP: begin
				i = sp;
				while (i > 0 && !found) begin
					i--;
					if (frame_kind[i] == KIND_ANNOT)
						found = 1'b1;
				end
				if (found)
					sp = i;
				else
					res.status = ST_UNDERFLOW;
			end
			default: begin
				if (req == REQ_RAISE) begin
					saved_sp  = sp;
					unwinding = 1'b1;
					cur_class = cls;
				end
				res.status = ST_UNCAUGHT;
				while (sp > 0 && !found) begin
					sp--;
					if (frame_kind[sp] == KIND_CATCH_ALL ||
							(frame_kind[sp] == KIND_CATCH && frame_class[sp] == cur_class)) begin
						unwinding = 1'b0;
						res.handler_tag = frame_tag[sp];
						res.status = ST_CAUGHT;
						found = 1'b1;
					end else if (frame_kind[sp] == KIND_FINALLY) begin
						res.handler_tag = frame_tag[sp];
						res.status = ST_FINALLY;
						found = 1'b1;
					end
				end
				if (!found) begin
					sp = saved_sp;
					unwinding = 1'b0;
				end
			end
		endcase
		res.new_depth = 7'(sp);
		res.still_unwinding = unwinding;
		return res;
	endfunction

	task automatic send_request(req_t req, logic [15:0] cls, logic [31:0] tg, bit typed,
			outcome_t want);
		int       gap;
		outcome_t pred;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		class_id <= cls;
		tag      <= tg;
		do @(posedge clk); while (in_stall);
		pred = predict_request(req, cls, tg);
		expected_q.push_back(typed ? want : pred);
		sent++;
	endtask

	task automatic add_row(req_t req, logic [15:0] cls, logic [31:0] tg, bit typed,
			status_t st, logic [6:0] depth);
		row_t r;
		r.req   = req;
		r.cls   = cls;
		r.tg    = tg;
		r.typed = typed;
		r.want  = '{status: st, handler_tag: 32'h0, new_depth: depth, still_unwinding: 1'b0};
		rows.push_back(r);
	endtask

	// receiver: hold stall for a random count of cycles after each beat
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			n = no_idle ? 0 : $urandom_range(0, 3);
			stall_left <= n;
			out_stall  <= (n != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_beat
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d tag %h depth %0d unw %0b",
						status, handler_tag, new_depth, still_unwinding);
			end else begin
				want = expected_q.pop_front();
				beats++;
				st_seen[want.status]++;
				if (status !== want.status || handler_tag !== want.handler_tag ||
						new_depth !== want.new_depth ||
						still_unwinding !== want.still_unwinding) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at beat %0d: status %0d/%0d tag %h/%h depth %0d/%0d unw %0b/%0b",
							beats, want.status, status, want.handler_tag, handler_tag,
							want.new_depth, new_depth, want.still_unwinding, still_unwinding);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, expected_q.size());
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		logic [15:0] pool [4];
		logic [15:0] cls;
		logic [31:0] tg;
		req_t        req;
		outcome_t    none;
		int          r;
		int          push_bias;
		int          n;
		bit          deep;
		pool = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF};
		none = '0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		req_type = 3'd0;
		class_id = 16'h0000;
		tag      = 32'h0;
		sp        = 0;
		saved_sp  = 0;
		unwinding = 1'b0;
		cur_class = 16'h0000;
		foreach (st_seen[k])
			st_seen[k] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(REQ_POP,          16'h0000, 32'h00000000, 1, ST_UNDERFLOW, 7'd0);
		add_row(REQ_ANNOT_POP,    16'h0000, 32'h00000000, 1, ST_UNDERFLOW, 7'd0);
		add_row(REQ_CONTINUE,     16'h0000, 32'h00000000, 1, ST_UNCAUGHT,  7'd0);
		add_row(REQ_RAISE,        16'hFFFF, 32'hFFFFFFFF, 1, ST_UNCAUGHT,  7'd0);
		add_row(REQ_PUSH_ANNOT,   16'hFFFF, 32'hFFFFFFFF, 1, ST_DONE,      7'd1);
		add_row(REQ_PUSH_ALL,     16'h1234, 32'h00000000, 1, ST_DONE,      7'd2);
		add_row(REQ_PUSH_CATCH,   16'hFFFF, 32'hFFFFFFFF, 1, ST_DONE,      7'd3);
		add_row(REQ_PUSH_FINALLY, 16'h0000, 32'hA5A5A5A5, 1, ST_DONE,      7'd4);
		add_row(REQ_PUSH_CATCH,   16'h0000, 32'h5A5A5A5A, 1, ST_DONE,      7'd5);
		add_row(REQ_RAISE,        16'hFFFF, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_CONTINUE,     16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_CONTINUE,     16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_CONTINUE,     16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_ANNOT_POP,    16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_PUSH_ALL,     16'h0000, 32'h00000001, 0, ST_DONE,      7'd0);
		add_row(REQ_PUSH_ANNOT,   16'h0000, 32'h00000002, 0, ST_DONE,      7'd0);
		add_row(REQ_PUSH_CATCH,   16'h0005, 32'h00000003, 0, ST_DONE,      7'd0);
		add_row(REQ_ANNOT_POP,    16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_POP,          16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		add_row(REQ_POP,          16'h0000, 32'h00000000, 1, ST_UNDERFLOW, 7'd0);
		add_row(REQ_RAISE,        16'h0000, 32'h00000000, 0, ST_DONE,      7'd0);
		foreach (rows[k])
			send_request(rows[k].req, rows[k].cls, rows[k].tg, rows[k].typed, rows[k].want);

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n == RAND_ITEMS / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (expected_q.size() != 0);
			end
			if (n == 250 || n == 600 || n == 800) begin
				// fill to the top, overflow, then walk down from full
				deep = (n == 250);
				while (sp < DEPTH) begin
					r = $urandom_range(0, 15);
					if (!deep && r == 0)
						req = REQ_PUSH_ALL;
					else if (!deep && r == 1)
						req = REQ_PUSH_FINALLY;
					else if (r < 9)
						req = REQ_PUSH_ANNOT;
					else
						req = REQ_PUSH_CATCH;
					send_request(req, pool[$urandom_range(0, 3)], $urandom, 0, none);
				end
				repeat ($urandom_range(1, 3))
					send_request(req_t'(3'($urandom_range(0, 3))), 16'($urandom), $urandom,
						0, none);
				send_request(REQ_RAISE, 16'hBEEF, $urandom, 0, none);
				send_request(REQ_CONTINUE, 16'($urandom), $urandom, 0, none);
			end
			r = $urandom_range(0, 99);
			push_bias = (sp < 8) ? 55 : ((sp > 48) ? 25 : 40);
			cls = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pool[$urandom_range(0, 3)];
			tg = $urandom;
			if (r < push_bias)
				req = req_t'(3'($urandom_range(0, 3)));
			else if (r < push_bias + 12)
				req = REQ_POP;
			else if (r < push_bias + 20)
				req = REQ_ANNOT_POP;
			else if (r < push_bias + 36)
				req = REQ_RAISE;
			else if (r < push_bias + 48)
				req = REQ_CONTINUE;
			else
				req = req_t'(3'($urandom_range(0, 7)));
			send_request(req, cls, tg, 0, none);
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0d expected beats never arrived", expected_q.size());
		end
		$display("covered %0d requests and %0d beats, %0d mismatches", sent, beats, errors);
		$display("status mix: done %0d caught %0d finally %0d uncaught %0d overflow %0d underflow %0d",
			st_seen[ST_DONE], st_seen[ST_CAUGHT], st_seen[ST_FINALLY],
			st_seen[ST_UNCAUGHT], st_seen[ST_OVERFLOW], st_seen[ST_UNDERFLOW]);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ehs_pkg.sv
rtl/ehs_ram.sv
rtl/exception_handler_stack.sv
tb/testbench.sv
